// ----- src/color_key_sprite_blitter_macros.svh -----
// Assertion macros shared by the blitter modules.
// Every module that uses them has ports named i_clk and i_rst_n.
`ifndef COLOR_KEY_SPRITE_BLITTER_MACROS_SVH
`define COLOR_KEY_SPRITE_BLITTER_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define CKB_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define CKB_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ----- src/ckb_pkg.sv -----
package ckb_pkg;

    localparam int MAX_SPRITE_DIM = 1024;

    localparam int CFG_POS_W  = 11;
    localparam int CFG_DIM_W  = 11;
    localparam int ORIENT_W   = 2;
    localparam int PIXEL_W    = 32;
    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Counter and clamped-size widths follow from the largest sprite side.
    localparam int CNT_W = $clog2(MAX_SPRITE_DIM);
    localparam int DIM_W = $clog2(MAX_SPRITE_DIM + 1);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 3'd5;

    // Orientation codes.
    localparam logic [ORIENT_W-1:0] ORIENT_NORMAL = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_TURNED = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_LEFT   = 2'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_RIGHT  = 2'd3;

    localparam logic [PIXEL_W-1:0] KEY_COLOR_RST = 32'h00FF_FFFE;

    typedef struct packed {
        logic [CFG_POS_W-1:0] origin_x;
        logic [CFG_POS_W-1:0] origin_y;
        logic [CFG_DIM_W-1:0] sprite_width;
        logic [CFG_DIM_W-1:0] sprite_height;
        logic [ORIENT_W-1:0]  orientation;
        logic [PIXEL_W-1:0]   key_color;
    } t_cfg;

    // One pixel with its source position, handed from the scan stage to the mapper.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [CNT_W-1:0]   col;
        logic [CNT_W-1:0]   row;
        logic               last;
    } t_scan_item;

    // A size of zero acts as one, a size above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return DIM_W'(1);
        end else if (v32 > 32'(MAX_SPRITE_DIM)) begin
            return DIM_W'(MAX_SPRITE_DIM);
        end
        return DIM_W'(v32);
    endfunction

endpackage

// ----- src/color_key_sprite_blitter.sv -----
// Path: a pixel accepted into the input register is mapped into the result register,
// which the frame buffer takes it from; a stall can hold it in either register.
// Throughput: one pixel per cycle unless the frame buffer stalls, set by the input and
// result registers, each of which loads whenever the stage after it moves or is empty.
// Reset (i_rst_n, synchronous, active low) clears both counters, both valid flags and
// loads the register defaults: origin 0,0, size 1x1, normal orientation, key 0x00FFFFFE.
module color_key_sprite_blitter
    import ckb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Source pixel channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIXEL_W-1:0]    i_pixel_color,
    // Frame-buffer write channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_W-1:0]    o_dest_x,
    output logic [COORD_W-1:0]    o_dest_y,
    output logic [PIXEL_W-1:0]    o_write_color,
    output logic                  o_write_enable,
    output logic                  o_sprite_end,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The design is a two-register pipeline. The scan stage keeps the column and
    // row counters; each accepted beat is captured together with the source
    // position it belongs to and a flag that marks the last pixel of the sprite.
    // The counters advance at that same edge, so back-to-back beats see the
    // right position without waiting for the mapper.
    //
    // The mapper turns the source position into a frame-buffer coordinate for
    // the selected orientation, compares the pixel against the key color and
    // loads the result register. Every stage moves when the stage after it is
    // empty or is being emptied, so the source is stalled only while a full
    // result register is itself stalled and the input register is occupied.
    //
    // Configuration is expected to change only while the pipe is empty; both
    // stages read the live register values.

    t_cfg       cfg;
    logic       item_valid;
    t_scan_item item;
    logic       take;

    ckb_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ckb_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_pixel_color (i_pixel_color),
        .o_stall       (o_stall),
        .i_cfg         (cfg),
        .i_take        (take),
        .o_item_valid  (item_valid),
        .o_item        (item)
    );

    ckb_map u_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_item_valid   (item_valid),
        .i_item         (item),
        .o_take         (take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_dest_x       (o_dest_x),
        .o_dest_y       (o_dest_y),
        .o_write_color  (o_write_color),
        .o_write_enable (o_write_enable),
        .o_sprite_end   (o_sprite_end)
    );

endmodule

// ----- src/ckb_cfg_regs.sv -----
module ckb_cfg_regs
    import ckb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X:      n_cfg.origin_x      = i_cfg_data[CFG_POS_W-1:0];
                REG_ORIGIN_Y:      n_cfg.origin_y      = i_cfg_data[CFG_POS_W-1:0];
                REG_SPRITE_WIDTH:  n_cfg.sprite_width  = i_cfg_data[CFG_DIM_W-1:0];
                REG_SPRITE_HEIGHT: n_cfg.sprite_height = i_cfg_data[CFG_DIM_W-1:0];
                REG_ORIENTATION:   n_cfg.orientation   = i_cfg_data[ORIENT_W-1:0];
                REG_KEY_COLOR:     n_cfg.key_color     = i_cfg_data[PIXEL_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.sprite_width  <= CFG_DIM_W'(1);
            r_cfg.sprite_height <= CFG_DIM_W'(1);
            r_cfg.orientation   <= ORIENT_NORMAL;
            r_cfg.key_color     <= KEY_COLOR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- src/ckb_scan.sv -----
module ckb_scan
    import ckb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [PIXEL_W-1:0] i_pixel_color,
    output logic               o_stall,
    input  t_cfg               i_cfg,
    input  logic               i_take,
    output logic               o_item_valid,
    output t_scan_item         o_item
);

`include "color_key_sprite_blitter_macros.svh"

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic             r_valid, n_valid;
    t_scan_item       r_item;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             accept;
    logic             row_last;
    logic             sprite_last;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    assign w = clamp_dim(i_cfg.sprite_width);
    assign h = clamp_dim(i_cfg.sprite_height);

    // A counter at or past its last value counts as being at its last value.
    assign row_last    = DIM_W'(r_col) >= (w - DIM_W'(1));
    assign sprite_last = row_last && (DIM_W'(r_row) >= (h - DIM_W'(1)));

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
            if (sprite_last) begin
                n_col = '0;
                n_row = '0;
            end else if (row_last) begin
                n_col = '0;
                n_row = r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.pixel <= i_pixel_color;
            r_item.col   <= r_col;
            r_item.row   <= r_row;
            r_item.last  <= sprite_last;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    `CKB_ASSERT_NEXT(a_scan_wrap, accept && sprite_last, (r_col == '0) && (r_row == '0), "counters did not restart after the last pixel")
    `CKB_ASSERT_NEXT(a_scan_hold, r_valid && !i_take, r_valid && $stable(r_item), "held item was lost or changed")

endmodule

// ----- src/ckb_map.sv -----
module ckb_map
    import ckb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_item_valid,
    input  t_scan_item         i_item,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COORD_W-1:0] o_dest_x,
    output logic [COORD_W-1:0] o_dest_y,
    output logic [PIXEL_W-1:0] o_write_color,
    output logic               o_write_enable,
    output logic               o_sprite_end
);

`include "color_key_sprite_blitter_macros.svh"

    logic               r_valid;
    logic [COORD_W-1:0] r_dest_x, n_dest_x;
    logic [COORD_W-1:0] r_dest_y, n_dest_y;
    logic [PIXEL_W-1:0] r_color;
    logic               r_we;
    logic               r_end;
    logic [COORD_W-1:0] ox, oy, wc, hc, cc, rc;

    assign o_take = !r_valid || !i_stall;

    // All coordinate arithmetic wraps modulo the coordinate width.
    assign ox = COORD_W'(i_cfg.origin_x);
    assign oy = COORD_W'(i_cfg.origin_y);
    assign wc = COORD_W'(clamp_dim(i_cfg.sprite_width));
    assign hc = COORD_W'(clamp_dim(i_cfg.sprite_height));
    assign cc = COORD_W'(i_item.col);
    assign rc = COORD_W'(i_item.row);

    always_comb begin
        unique case (i_cfg.orientation)
            ORIENT_NORMAL: begin
                n_dest_x = ox + cc;
                n_dest_y = oy + rc;
            end
            ORIENT_TURNED: begin
                n_dest_x = ox + wc - COORD_W'(1) - cc;
                n_dest_y = oy + hc - COORD_W'(1) - rc;
            end
            ORIENT_LEFT: begin
                n_dest_x = ox + rc;
                n_dest_y = oy + wc - cc;
            end
            default: begin
                n_dest_x = ox + hc - rc;
                n_dest_y = oy + cc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item_valid) begin
            r_dest_x <= n_dest_x;
            r_dest_y <= n_dest_y;
            r_color  <= i_item.pixel;
            r_we     <= i_item.pixel != i_cfg.key_color;
            r_end    <= i_item.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_dest_x       = r_dest_x;
    assign o_dest_y       = r_dest_y;
    assign o_write_color  = r_color;
    assign o_write_enable = r_we;
    assign o_sprite_end   = r_end;

    `CKB_ASSERT_NOW(a_map_key, r_valid, r_we == (r_color != i_cfg.key_color), "write enable disagrees with key compare")
    `CKB_ASSERT_NEXT(a_map_fill, i_item_valid && o_take, r_valid && (r_color == $past(i_item.pixel)), "taken item missing from result register")

endmodule

// ----- test/color_key_sprite_blitter_tb.sv -----
module color_key_sprite_blitter_tb
    import ckb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The run ends here at the latest.
    localparam int CYCLE_LIMIT = 200_000;
    // Random beats to send after the directed part.
    localparam int RANDOM_BEATS = 1250;
    // Receiver hold-off length used to fill the block and back up the source channel.
    localparam int HOLD_CYCLES = 80;
    // Indexes past the end of the register list. The block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // One frame-buffer write as it leaves the block.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIXEL_W-1:0] color;
        logic               enable;
        logic               last;
    } t_blit_write;

    // Tracks the register file and the source scan position, turns every accepted
    // pixel into the write it should produce, and compares the writes that come out.
    class t_blit_scoreboard;
        logic [CFG_POS_W-1:0] org_x;
        logic [CFG_POS_W-1:0] org_y;
        logic [CFG_DIM_W-1:0] width_reg;
        logic [CFG_DIM_W-1:0] height_reg;
        logic [ORIENT_W-1:0]  orient;
        logic [PIXEL_W-1:0]   key;
        int unsigned          col_pos;
        int unsigned          row_pos;
        t_blit_write          expected_writes[$];
        int                   errors;

        function new();
            org_x      = '0;
            org_y      = '0;
            width_reg  = CFG_DIM_W'(1);
            height_reg = CFG_DIM_W'(1);
            orient     = ORIENT_NORMAL;
            key        = KEY_COLOR_RST;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
        endfunction

        // A size of zero behaves as one, anything above the maximum as the maximum.
        function int unsigned eff_dim(logic [CFG_DIM_W-1:0] v);
            if (v == '0) return 1;
            if (int'(v) > MAX_SPRITE_DIM) return MAX_SPRITE_DIM;
            return int'(v);
        endfunction

        function int unsigned sprite_area();
            return eff_dim(width_reg) * eff_dim(height_reg);
        endfunction

        function int outstanding();
            return expected_writes.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ORIGIN_X:      org_x = data[CFG_POS_W-1:0];
                REG_ORIGIN_Y:      org_y = data[CFG_POS_W-1:0];
                REG_SPRITE_WIDTH:  width_reg = data[CFG_DIM_W-1:0];
                REG_SPRITE_HEIGHT: height_reg = data[CFG_DIM_W-1:0];
                REG_ORIENTATION:   orient = data[ORIENT_W-1:0];
                REG_KEY_COLOR:     key = data[PIXEL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] pix);
            int unsigned w;
            int unsigned h;
            logic [31:0] dx;
            logic [31:0] dy;
            bit          row_done;
            bit          sprite_done;
            t_blit_write wr;
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            // Unsigned 32-bit arithmetic; only the low coordinate bits are kept, so an
            // underflow or an overflow wraps around the frame buffer.
            case (orient)
                ORIENT_NORMAL: begin
                    dx = org_x + col_pos;
                    dy = org_y + row_pos;
                end
                ORIENT_TURNED: begin
                    dx = org_x + w - 1 - col_pos;
                    dy = org_y + h - 1 - row_pos;
                end
                ORIENT_LEFT: begin
                    dx = org_x + row_pos;
                    dy = org_y + w - col_pos;
                end
                default: begin
                    dx = org_x + h - row_pos;
                    dy = org_y + col_pos;
                end
            endcase
            // A counter left past its end by a size change counts as being at the end.
            row_done    = (col_pos >= w - 1);
            sprite_done = row_done && (row_pos >= h - 1);
            if (sprite_done) begin
                col_pos = 0;
                row_pos = 0;
            end else if (row_done) begin
                col_pos = 0;
                row_pos = row_pos + 1;
            end else begin
                col_pos = col_pos + 1;
            end
            wr.x      = dx[COORD_W-1:0];
            wr.y      = dy[COORD_W-1:0];
            wr.color  = pix;
            wr.enable = (pix != key);
            wr.last   = sprite_done;
            expected_writes.push_back(wr);
        endfunction

        function void compare(string field, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp, act);
            end
        endfunction

        function void check_write(t_blit_write got);
            t_blit_write exp;
            if (expected_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected write, expected none, got x=%0h y=%0h color=%0h",
                         $time, got.x, got.y, got.color);
                return;
            end
            exp = expected_writes.pop_front();
            compare("dest_x", 32'(exp.x), 32'(got.x));
            compare("dest_y", 32'(exp.y), 32'(got.y));
            compare("write_color", exp.color, got.color);
            compare("write_enable", 32'(exp.enable), 32'(got.enable));
            compare("sprite_end", 32'(exp.last), 32'(got.last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [PIXEL_W-1:0]    i_pixel_color;
    logic                  o_valid;
    logic                  i_stall;
    logic [COORD_W-1:0]    o_dest_x;
    logic [COORD_W-1:0]    o_dest_y;
    logic [PIXEL_W-1:0]    o_write_color;
    logic                  o_write_enable;
    logic                  o_sprite_end;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_blit_scoreboard sb = new();

    // Idle rates in percent for the source side and for the write side.
    int   tx_idle = 0;
    int   rx_idle = 0;
    // A request for one long receiver hold-off, served by the stall process.
    logic hold_req;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   random_sent = 0;
    int   phase_no = 0;

    color_key_sprite_blitter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_color  (i_pixel_color),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_dest_x       (o_dest_x),
        .o_dest_y       (o_dest_y),
        .o_write_color  (o_write_color),
        .o_write_enable (o_write_enable),
        .o_sprite_end   (o_sprite_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The write side. Normally it stalls at the rate of the current phase. When a
    // hold-off is requested it stalls without a break for the hold-off length, long
    // enough for the block to fill up and push back on the source channel.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle);
        end
    end

    // Every write beat taken by the frame buffer is checked against the oldest
    // expected write. The outputs are sampled at the edge that takes the beat.
    always @(posedge i_clk) begin
        t_blit_write got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.x      = o_dest_x;
            got.y      = o_dest_y;
            got.color  = o_write_color;
            got.enable = o_write_enable;
            got.last   = o_sprite_end;
            sb.check_write(got);
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offers one source pixel and returns at the edge that takes it. The source side
    // may first go idle, at the rate of the current phase.
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
        while ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_color <= pix;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(pix);
    endtask

    // Writes one register. The valid is left high so that back-to-back writes go out
    // on consecutive cycles; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Stops the source and waits until every expected write has come out, so that
    // the registers can be changed with nothing in flight.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Pixels hit the key exactly, miss it by a single bit, or, most often, are random.
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return sb.key;
        if (r < 35) return sb.key ^ (32'd1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    // Origins favor the two ends of the range. The unused upper data bits are often
    // set to show that the register keeps only its own width.
    function automatic logic [CFG_DATA_W-1:0] pick_origin();
        int          r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 15) v = 0;
        else if (r < 30) v = 2047;
        else v = $urandom_range(0, 2047);
        if ($urandom_range(0, 1)) v = v | ($urandom & 32'hFFFF_F800);
        return v;
    endfunction

    // Sizes are mostly small so that many complete sprites go through. A few are
    // zero or above the maximum, and a few are large; those phases end mid-sprite.
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int          r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 65) v = $urandom_range(1, 8);
        else if (r < 85) v = $urandom_range(9, 40);
        else if (r < 90) v = 0;
        else if (r < 95) v = $urandom_range(MAX_SPRITE_DIM + 1, 2047);
        else v = $urandom_range(41, MAX_SPRITE_DIM);
        if ($urandom_range(0, 3) == 0) v = v | ($urandom & 32'hFFFF_F800);
        return v;
    endfunction

    initial begin
        int unsigned area;
        int          beats;
        int          r;
        logic [31:0] key_val;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_pixel_color <= '0;
        i_stall       <= 1'b0;
        hold_req      <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_ORIGIN_X;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling on either side.

        // Reset values: a 1x1 sprite at the origin, so every pixel ends a sprite. The
        // first pixel equals the reset key and must not be written.
        send_pixel(KEY_COLOR_RST);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        settle();

        // Zero sizes act as one. Origin at the far corner with the right turn pushes
        // dest_x past the top of the range. A key of zero suppresses a zero pixel.
        write_reg(REG_ORIGIN_X, 32'hFFFF_FFFF);
        write_reg(REG_ORIGIN_Y, 32'hFFFF_FFFF);
        write_reg(REG_SPRITE_WIDTH, 32'h0000_0000);
        write_reg(REG_SPRITE_HEIGHT, 32'h0000_0000);
        write_reg(REG_ORIENTATION, {30'h0, ORIENT_RIGHT});
        write_reg(REG_KEY_COLOR, 32'h0000_0000);
        i_cfg_valid <= 1'b0;
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_0001);
        settle();

        // One whole 3x2 sprite turned half way round, keyed on all ones.
        write_reg(REG_ORIGIN_X, 32'h0000_0000);
        write_reg(REG_ORIGIN_Y, 32'h0000_0000);
        write_reg(REG_SPRITE_WIDTH, 32'd3);
        write_reg(REG_SPRITE_HEIGHT, 32'd2);
        write_reg(REG_ORIENTATION, {30'h0, ORIENT_TURNED});
        write_reg(REG_KEY_COLOR, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        repeat (4) send_pixel($urandom);
        settle();

        // A 2x2 sprite turned left from the far corner, so both coordinates can pass 2047.
        write_reg(REG_ORIGIN_X, 32'd2047);
        write_reg(REG_ORIGIN_Y, 32'd2047);
        write_reg(REG_SPRITE_WIDTH, 32'd2);
        write_reg(REG_SPRITE_HEIGHT, 32'd2);
        write_reg(REG_ORIENTATION, {30'h0, ORIENT_LEFT});
        write_reg(REG_KEY_COLOR, 32'hAAAA_5555);
        i_cfg_valid <= 1'b0;
        send_pixel(32'hAAAA_5555);
        send_pixel(32'h5555_AAAA);
        send_pixel(32'hAAAA_5554);
        send_pixel($urandom);
        settle();

        // Stop a 4x2 sprite in its second row, then shrink the width to one under the
        // half turn: the column is past its new end, the row and the sprite end at
        // once, and dest_x underflows. Writes to indexes past the list change nothing.
        write_reg(REG_ORIGIN_X, 32'h0000_0000);
        write_reg(REG_ORIGIN_Y, 32'h0000_0000);
        write_reg(REG_SPRITE_WIDTH, 32'd4);
        write_reg(REG_ORIENTATION, {30'h0, ORIENT_NORMAL});
        i_cfg_valid <= 1'b0;
        repeat (5) send_pixel($urandom);
        settle();
        write_reg(REG_SPRITE_WIDTH, 32'd1);
        write_reg(REG_ORIENTATION, {30'h0, ORIENT_TURNED});
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_pixel($urandom);
        send_pixel($urandom);
        settle();

        // Sizes above the maximum act as the maximum.
        write_reg(REG_SPRITE_WIDTH, 32'd2047);
        write_reg(REG_SPRITE_HEIGHT, 32'd1025);
        write_reg(REG_ORIENTATION, {30'h0, ORIENT_RIGHT});
        i_cfg_valid <= 1'b0;
        repeat (3) send_pixel($urandom);
        settle();

        // Random part, in phases. Each phase starts from an idle block, rewrites a
        // random subset of the registers and then streams pixels. Phases with small
        // sprites send whole sprites, sometimes with a partial one on the end, so
        // later phases often begin mid-sprite under a new size.
        while (random_sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 99) < 70) write_reg(REG_ORIGIN_X, pick_origin());
            if ($urandom_range(0, 99) < 70) write_reg(REG_ORIGIN_Y, pick_origin());
            if ($urandom_range(0, 99) < 70) write_reg(REG_SPRITE_WIDTH, pick_dim());
            if ($urandom_range(0, 99) < 70) write_reg(REG_SPRITE_HEIGHT, pick_dim());
            if ($urandom_range(0, 99) < 80) write_reg(REG_ORIENTATION, $urandom);
            if ($urandom_range(0, 99) < 50) begin
                r = $urandom_range(0, 3);
                key_val = (r == 0) ? 32'h0000_0000 :
                          (r == 1) ? 32'hFFFF_FFFF : $urandom;
                write_reg(REG_KEY_COLOR, key_val);
            end
            if ($urandom_range(0, 99) < 10)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            i_cfg_valid <= 1'b0;

            area = sb.sprite_area();
            if (area <= 64) begin
                beats = area * $urandom_range(1, 4);
                if ($urandom_range(0, 99) < 20) beats += $urandom_range(0, area - 1);
            end else begin
                beats = $urandom_range(16, 120);
            end

            // Rotate through the idling patterns: none, source only, write side only,
            // both. The first phase instead runs flat out against a long hold-off.
            case (phase_no % 4)
                0: begin tx_idle = 0;  rx_idle = 0;  end
                1: begin tx_idle = 45; rx_idle = 0;  end
                2: begin tx_idle = 0;  rx_idle = 45; end
                default: begin tx_idle = 25; rx_idle = 25; end
            endcase
            if (phase_no == 0) begin
                hold_req <= 1'b1;
                if (beats < 150) beats = 150;
            end

            repeat (beats) send_pixel(pick_pixel());
            random_sent += beats;
            phase_no++;
            settle();
        end

        // Drain: everything has been accepted and every write has come out. Waiting on
        // before the final check catches any stray write after the last expected one.
        tx_idle = 0;
        rx_idle = 0;
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
